// File: src/bnlj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlj_pkg
// Shared types and constants of the block nested loop equi-join engine:
// request and result payloads, microcode control word and datapath status.
// ----------------------------------------------------------------------------
package bnlj_pkg;

  localparam int unsigned BlockDepthDefault = 64;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StepW = 4;

  localparam logic [ModeW-1:0] ModeClear = 2'd0;
  localparam logic [ModeW-1:0] ModeLoad = 2'd1;
  localparam logic [ModeW-1:0] ModeProbe = 2'd2;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepFetch = 4'd0;
  localparam step_t StepIsClear = 4'd1;
  localparam step_t StepIsLoad = 4'd2;
  localparam step_t StepIsProbe = 4'd3;
  localparam step_t StepDrop = 4'd4;
  localparam step_t StepClear = 4'd5;
  localparam step_t StepLoad = 4'd6;
  localparam step_t StepWrite = 4'd7;
  localparam step_t StepOvf = 4'd8;
  localparam step_t StepProbe = 4'd9;
  localparam step_t StepScan = 4'd10;
  localparam step_t StepFlush = 4'd11;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [KeyW-1:0]   tuple_key;
    logic [ValueW-1:0] tuple_value;
  } in_req_t;

  typedef struct packed {
    logic              matched;
    logic [KeyW-1:0]   left_key;
    logic [ValueW-1:0] left_value;
    logic [KeyW-1:0]   right_key;
    logic [ValueW-1:0] right_value;
    logic              last_of_run;
    logic              overflow;
  } out_res_t;

  typedef enum logic [3:0] {
    CondNever     = 4'd0,
    CondAlways    = 4'd1,
    CondNoReq     = 4'd2,
    CondOutBusy   = 4'd3,
    CondModeClear = 4'd4,
    CondModeLoad  = 4'd5,
    CondModeProbe = 4'd6,
    CondFull      = 4'd7,
    CondScanStall = 4'd8,
    CondScanMore  = 4'd9
  } cond_e;

  typedef enum logic [2:0] {
    OpNop       = 3'd0,
    OpAccept    = 3'd1,
    OpClrFill   = 3'd2,
    OpWrite     = 3'd3,
    OpEmitOvf   = 3'd4,
    OpScanInit  = 3'd5,
    OpScan      = 3'd6,
    OpEmitFinal = 3'd7
  } op_e;

  typedef struct packed {
    cond_e hold_c;
    op_e   op;
    cond_e br_c;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             full;
    logic             out_busy;
    logic             scan_stall;
    logic             scan_more;
  } dp_status_t;

endpackage

// File: src/block_nested_loop_equijoin.sv
`timescale 1ns / 1ps
// During a probe the scan reads one buffered tuple per cycle through the
// buffer's single read port, unless held by a match waiting on a busy output.
// One request at a time; the next is taken while a result waits in the output
// register. Reset empties the buffer (fill count zero); contents are not cleared.
// ----------------------------------------------------------------------------
// block_nested_loop_equijoin
// Equi-join engine for one block of a block nested loop join, controlled by
// a microcoded sequencer over a buffer and scan datapath.
// ----------------------------------------------------------------------------
module block_nested_loop_equijoin #(
  parameter int unsigned BlockDepth = bnlj_pkg::BlockDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bnlj_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bnlj_pkg::out_res_t out_res_o
);
  import bnlj_pkg::*;

  dp_status_t status;
  op_e        op;

  bnlj_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  bnlj_datapath #(
    .BlockDepth (BlockDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .op_i        (op),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

// File: src/bnlj_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlj_sequencer
// Step counter and microcode table. Each control word holds the step on a
// condition, issues one datapath operation and jumps on a second condition.
// ----------------------------------------------------------------------------
module bnlj_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  bnlj_pkg::dp_status_t   status_i,
  output logic                   in_stall_o,
  output bnlj_pkg::op_e          op_o
);
  import bnlj_pkg::*;

  step_t      pc_q, pc_d;
  ctrl_word_t ctrl;
  logic       hold;
  logic       taken;

  function automatic ctrl_word_t rom_word(step_t step);
    ctrl_word_t w;
    unique case (step)
      StepFetch:   w = '{CondNoReq,     OpAccept,    CondNever,     StepFetch};
      StepIsClear: w = '{CondNever,     OpNop,       CondModeClear, StepClear};
      StepIsLoad:  w = '{CondNever,     OpNop,       CondModeLoad,  StepLoad};
      StepIsProbe: w = '{CondNever,     OpNop,       CondModeProbe, StepProbe};
      StepDrop:    w = '{CondNever,     OpNop,       CondAlways,    StepFetch};
      StepClear:   w = '{CondNever,     OpClrFill,   CondAlways,    StepFetch};
      StepLoad:    w = '{CondNever,     OpNop,       CondFull,      StepOvf};
      StepWrite:   w = '{CondNever,     OpWrite,     CondAlways,    StepFetch};
      StepOvf:     w = '{CondOutBusy,   OpEmitOvf,   CondAlways,    StepFetch};
      StepProbe:   w = '{CondNever,     OpScanInit,  CondNever,     StepFetch};
      StepScan:    w = '{CondScanStall, OpScan,      CondScanMore,  StepScan};
      StepFlush:   w = '{CondOutBusy,   OpEmitFinal, CondAlways,    StepFetch};
      default:     w = '{CondNever,     OpNop,       CondAlways,    StepFetch};
    endcase
    return w;
  endfunction

  function automatic logic eval_cond(cond_e c, dp_status_t s, logic vld);
    logic r;
    unique case (c)
      CondNever:     r = 1'b0;
      CondAlways:    r = 1'b1;
      CondNoReq:     r = !vld;
      CondOutBusy:   r = s.out_busy;
      CondModeClear: r = (s.mode == ModeClear);
      CondModeLoad:  r = (s.mode == ModeLoad);
      CondModeProbe: r = (s.mode == ModeProbe);
      CondFull:      r = s.full;
      CondScanStall: r = s.scan_stall;
      CondScanMore:  r = s.scan_more;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    ctrl  = rom_word(pc_q);
    hold  = eval_cond(ctrl.hold_c, status_i, in_valid_i);
    taken = eval_cond(ctrl.br_c, status_i, in_valid_i);
    if (hold) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  assign op_o       = hold ? OpNop : ctrl.op;
  assign in_stall_o = (ctrl.op != OpAccept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepFetch;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: src/bnlj_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlj_datapath
// Block buffer memory, fill count, scan pointer with registered read,
// pending match holder and result output register.
// ----------------------------------------------------------------------------
module bnlj_datapath #(
  parameter int unsigned BlockDepth = bnlj_pkg::BlockDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bnlj_pkg::in_req_t    in_req_i,
  input  bnlj_pkg::op_e        op_i,
  input  logic                 out_stall_i,
  output bnlj_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output bnlj_pkg::out_res_t   out_res_o
);
  import bnlj_pkg::*;

  localparam int unsigned AddrW = (BlockDepth > 1) ? $clog2(BlockDepth) : 1;
  localparam int unsigned FillW = $clog2(BlockDepth + 1);

  logic [KeyW-1:0]   mem_key   [BlockDepth];
  logic [ValueW-1:0] mem_value [BlockDepth];

  in_req_t           req_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  idx_q, idx_d;
  logic              rd_valid_q, rd_valid_d;
  logic [KeyW-1:0]   rd_key_q;
  logic [ValueW-1:0] rd_value_q;
  logic              pend_valid_q, pend_valid_d;
  logic [KeyW-1:0]   pend_key_q;
  logic [ValueW-1:0] pend_value_q;
  logic              out_valid_q;
  out_res_t          out_q;

  logic     full;
  logic     scan_issue;
  logic     hit;
  logic     out_busy;
  logic     emit;
  out_res_t emit_res;

  assign full       = (fill_q == FillW'(BlockDepth));
  assign scan_issue = (idx_q < fill_q);
  assign hit        = rd_valid_q && (rd_value_q == req_q.tuple_value);
  assign out_busy   = out_valid_q && out_stall_i;

  assign status_o.mode       = req_q.mode;
  assign status_o.full       = full;
  assign status_o.out_busy   = out_busy;
  assign status_o.scan_stall = hit && pend_valid_q && out_busy;
  assign status_o.scan_more  = scan_issue;

  always_comb begin
    emit         = 1'b0;
    emit_res     = '0;
    fill_d       = fill_q;
    idx_d        = idx_q;
    rd_valid_d   = rd_valid_q;
    pend_valid_d = pend_valid_q;
    unique case (op_i)
      OpClrFill: begin
        fill_d = '0;
      end
      OpWrite: begin
        fill_d = fill_q + FillW'(1);
      end
      OpEmitOvf: begin
        emit              = 1'b1;
        emit_res.overflow = 1'b1;
      end
      OpScanInit: begin
        idx_d        = '0;
        rd_valid_d   = 1'b0;
        pend_valid_d = 1'b0;
      end
      OpScan: begin
        rd_valid_d = scan_issue;
        if (scan_issue) begin
          idx_d = idx_q + FillW'(1);
        end
        if (hit) begin
          pend_valid_d = 1'b1;
          if (pend_valid_q) begin
            emit                 = 1'b1;
            emit_res.matched     = 1'b1;
            emit_res.left_key    = req_q.tuple_key;
            emit_res.left_value  = req_q.tuple_value;
            emit_res.right_key   = pend_key_q;
            emit_res.right_value = pend_value_q;
          end
        end
      end
      OpEmitFinal: begin
        emit                 = 1'b1;
        pend_valid_d         = 1'b0;
        emit_res.left_key    = req_q.tuple_key;
        emit_res.left_value  = req_q.tuple_value;
        emit_res.last_of_run = 1'b1;
        if (pend_valid_q) begin
          emit_res.matched     = 1'b1;
          emit_res.right_key   = pend_key_q;
          emit_res.right_value = pend_value_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      idx_q        <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OpAccept) begin
      req_q <= in_req_i;
    end
    if (emit) begin
      out_q <= emit_res;
    end
    if (op_i == OpScan && hit) begin
      pend_key_q   <= rd_key_q;
      pend_value_q <= rd_value_q;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (op_i == OpWrite) begin
      mem_key[fill_q[AddrW-1:0]]   <= req_q.tuple_key;
      mem_value[fill_q[AddrW-1:0]] <= req_q.tuple_value;
    end
    if (op_i == OpScan && scan_issue) begin
      rd_key_q   <= mem_key[idx_q[AddrW-1:0]];
      rd_value_q <= mem_value[idx_q[AddrW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// File: src/bnlj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlj_checker
// Port-level checks on the result channel of the equi-join engine.
// ----------------------------------------------------------------------------
module bnlj_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bnlj_pkg::out_res_t out_res_o
);
  import bnlj_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.overflow |->
      !out_res_o.matched && !out_res_o.last_of_run &&
      out_res_o.left_key == '0 && out_res_o.left_value == '0 &&
      out_res_o.right_key == '0 && out_res_o.right_value == '0)
    else $error("overflow result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.matched && !out_res_o.overflow |->
      out_res_o.last_of_run && out_res_o.right_key == '0 &&
      out_res_o.right_value == '0)
    else $error("malformed no-match result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.matched |->
      !out_res_o.overflow && out_res_o.right_value == out_res_o.left_value)
    else $error("match with unequal values");

endmodule

bind block_nested_loop_equijoin bnlj_checker u_bnlj_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

// File: test/block_nested_loop_equijoin_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_nested_loop_equijoin_check
// Passive checker for the equi-join engine. It follows the buffer contents
// from every accepted request, predicts the join results of each probe and
// the overflow result of each load into a full buffer, and compares each
// result of the engine field by field with the oldest prediction.
// Mismatches and the number of results still owed go to the testbench top.
// ----------------------------------------------------------------------------
module block_nested_loop_equijoin_check #(
  parameter int unsigned BlockDepth = bnlj_pkg::BlockDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  bnlj_pkg::in_req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  bnlj_pkg::out_res_t out_res_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  import bnlj_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic [KeyW-1:0]   join_keys   [BlockDepth];
  logic [ValueW-1:0] join_values [BlockDepth];
  int unsigned       join_fill = 0;
  out_res_t          pending_results [$];
  int unsigned       mismatch_count = 0;

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: mismatch on %0s, expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic predict_join(input in_req_t req);
    out_res_t res;
    out_res_t held;
    int unsigned hits;
    hits = 0;
    held = '0;
    case (req.mode)
      ModeClear: begin
        join_fill = 0;
      end
      ModeLoad: begin
        if (join_fill >= BlockDepth) begin
          res = '0;
          res.overflow = 1'b1;
          pending_results.push_back(res);
        end else begin
          join_keys[join_fill] = req.tuple_key;
          join_values[join_fill] = req.tuple_value;
          join_fill++;
        end
      end
      ModeProbe: begin
        for (int unsigned i = 0; i < join_fill; i++) begin
          if (join_values[i] == req.tuple_value) begin
            if (hits != 0) pending_results.push_back(held);
            held = '0;
            held.matched = 1'b1;
            held.left_key = req.tuple_key;
            held.left_value = req.tuple_value;
            held.right_key = join_keys[i];
            held.right_value = join_values[i];
            hits++;
          end
        end
        if (hits == 0) begin
          held = '0;
          held.left_key = req.tuple_key;
          held.left_value = req.tuple_value;
        end
        held.last_of_run = 1'b1;
        pending_results.push_back(held);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input out_res_t got);
    out_res_t want;
    if (pending_results.size() == 0) begin
      note_mismatch("result with none expected, left_key", '0, got.left_key);
    end else begin
      want = pending_results.pop_front();
      if (got.matched !== want.matched)
        note_mismatch("matched", want.matched, got.matched);
      if (got.left_key !== want.left_key)
        note_mismatch("left_key", want.left_key, got.left_key);
      if (got.left_value !== want.left_value)
        note_mismatch("left_value", want.left_value, got.left_value);
      if (got.right_key !== want.right_key)
        note_mismatch("right_key", want.right_key, got.right_key);
      if (got.right_value !== want.right_value)
        note_mismatch("right_value", want.right_value, got.right_value);
      if (got.last_of_run !== want.last_of_run)
        note_mismatch("last_of_run", want.last_of_run, got.last_of_run);
      if (got.overflow !== want.overflow)
        note_mismatch("overflow", want.overflow, got.overflow);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      join_fill = 0;
      pending_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_join(in_req_i);
      if (out_valid_i && !out_stall_i) check_result(out_res_i);
    end
    pending_o <= pending_results.size();
    errors_o <= mismatch_count;
  end

endmodule

// File: test/block_nested_loop_equijoin_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_nested_loop_equijoin_test
// Testbench of the equi-join engine. A short directed sequence covers the
// empty buffer, extreme keys and values, repeated matches, unused mode and
// clear. Random phases then clear, load and probe the buffer with values from
// small pools, fill it to overflow and mix in noise, with random gaps on both
// channels, one long output hold and a drain pause. A checker beside the
// engine predicts and compares every result.
// ----------------------------------------------------------------------------
module block_nested_loop_equijoin_test;
  import bnlj_pkg::*;

  localparam logic [ModeW-1:0] ModeReserved = 2'd3;
  localparam int unsigned ItemTarget = 480;
  localparam int unsigned QuietItems = 60;
  localparam int unsigned PressurePhase = 3;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned DrainLimit = 50000;
  localparam longint unsigned LimitNs = 40_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_res_t out_res_o;

  int unsigned results_owed;
  int unsigned join_errors;
  int unsigned req_count = 0;
  int unsigned hold_requests = 0;
  bit          quiet = 1'b0;

  logic [ValueW-1:0] value_pool [4];
  int unsigned       pool_size = 1;

  always #6 clk_i = ~clk_i;

  block_nested_loop_equijoin i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  block_nested_loop_equijoin_check i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_i  (out_res_o),
    .pending_o  (results_owed),
    .errors_o   (join_errors)
  );

  function automatic logic [ValueW-1:0] pool_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  task automatic put_req(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                         input logic [ValueW-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{mode: mode, tuple_key: key, tuple_value: value};
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    if (mode != ModeReserved) req_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (results_owed != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // output side: random stall bursts, one long hold on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_done;
    holds_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        out_stall_i <= 1'b1;
        hold_left = LongHoldCycles;
        while (hold_left != 0) begin
          @(negedge clk_i);
          hold_left--;
        end
        holds_done++;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned loads;
    logic [ValueW-1:0] run_value;
    phase = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    put_req(ModeProbe, 32'h0000_0000, 32'h0000_0000);
    put_req(ModeReserved, '1, '1);
    put_req(ModeLoad, '1, '1);
    put_req(ModeLoad, 32'h0000_0000, 32'h0000_0000);
    put_req(ModeLoad, 32'h1234_5678, '1);
    put_req(ModeLoad, 32'hA5A5_A5A5, 32'h0000_0000);
    put_req(ModeLoad, 32'h8000_0000, 32'h8000_0001);
    put_req(ModeProbe, '1, '1);
    put_req(ModeProbe, 32'h0000_0000, 32'h0000_0000);
    put_req(ModeProbe, 32'h5A5A_5A5A, 32'h8000_0001);
    put_req(ModeProbe, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_req(ModeReserved, 32'h0000_0000, 32'h0000_0000);
    put_req(ModeProbe, 32'h0000_0001, 32'h8000_0001);
    put_req(ModeClear, '1, '1);
    put_req(ModeProbe, '1, '1);
    put_req(ModeClear, 32'h0000_0000, 32'h0000_0000);
    put_req(ModeLoad, 32'hCAFE_0001, 32'h0000_0055);
    put_req(ModeProbe, 32'h0000_0001, 32'h0000_0055);

    while (req_count < ItemTarget) begin
      phase++;
      quiet = (req_count + QuietItems >= ItemTarget);
      if (phase == PressurePhase) begin
        put_req(ModeClear, $urandom, $urandom);
        run_value = $urandom;
        repeat (16) put_req(ModeLoad, $urandom, run_value);
        hold_requests++;
        repeat (6) put_req(ModeProbe, $urandom, run_value);
        wait_for_results();
      end else if (phase > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(4, 12))
          put_req(ModeW'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        pool_size = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(0, 5))
            0: value_pool[i] = '0;
            1: value_pool[i] = '1;
            default: value_pool[i] = $urandom;
          endcase
        end
        if (phase == 1 || $urandom_range(0, 3) != 0) put_req(ModeClear, $urandom, $urandom);
        if (phase == 1 || $urandom_range(0, 15) == 0) begin
          loads = BlockDepthDefault + $urandom_range(1, 3);
        end else begin
          loads = $urandom_range(0, 8);
        end
        repeat (loads) put_req(ModeLoad, $urandom, pool_value());
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 5) == 0) put_req(ModeLoad, $urandom, pool_value());
          put_req(ModeProbe, $urandom, pool_value());
        end
      end
    end

    wait_for_results();
    if (join_errors == 0 && results_owed == 0) begin
      $display("block_nested_loop_equijoin_test passed");
    end else begin
      $display("block_nested_loop_equijoin_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitNs);
    $display("block_nested_loop_equijoin_test failed");
    $finish;
  end

endmodule
